// ===== rtl/sff_pkg.sv =====
// ============================================================================
// sff_pkg
// Shared types and constants for the sensor frame finder.
// ============================================================================
package sff_pkg;

    localparam int STORE_DEPTH_DEF = 512;   // bytes in the receive store
    localparam int HDR_TRL_LEN     = 5;     // preamble, address, id, length, checksum
    localparam int HDR_LEN         = 4;     // bytes ahead of the first data byte
    localparam int OFF_W           = 9;     // offsets into a candidate, up to 259

    localparam logic [7:0] LEN_EXT_MARK = 8'hFF;

    localparam logic [7:0] PREAMBLE_RST = 8'd250;
    localparam logic [7:0] ADDRESS_RST  = 8'd255;
    localparam logic [7:0] MSG_ID_RST   = 8'd50;

    localparam int TOK_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_ID   = 2'd2;

    typedef struct packed {
        logic [7:0] preamble;
        logic [7:0] address;
        logic [7:0] msg_id;
    } cfg_t;

    // one data byte of a passing frame, front to back, or the marker of an empty frame
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] len;
        logic       last;
        logic       empty;
    } token_t;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic [7:0]  len;
        logic        last;
    } result_t;

endpackage

// ===== rtl/sff_fifo.sv =====
// ============================================================================
// sff_fifo
// Small synchronous FIFO built from registers.
// ============================================================================
module sff_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    import sff_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        cnt_next = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== rtl/sff_scanner.sv =====
// ============================================================================
// sff_scanner
// Byte store and frame search: header check, checksum, data byte streaming.
// ============================================================================
module sff_scanner #(
    parameter int STORE_DEPTH = sff_pkg::STORE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [7:0]      rx_byte,
    output logic            full,
    input  sff_pkg::cfg_t   cfg,
    input  logic            tok_full,
    output logic            tok_push,
    output sff_pkg::token_t tok
);
    import sff_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(STORE_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(STORE_DEPTH);

    localparam logic [2:0] ST_START  = 3'd0;
    localparam logic [2:0] ST_HREQ   = 3'd1;
    localparam logic [2:0] ST_HCHK   = 3'd2;
    localparam logic [2:0] ST_FWAIT  = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_EREQ   = 3'd5;
    localparam logic [2:0] ST_EPUSH  = 3'd6;
    localparam logic [2:0] ST_EEMPTY = 3'd7;

    localparam logic [1:0] POS_PRE  = 2'd0;
    localparam logic [1:0] POS_ADDR = 2'd1;
    localparam logic [1:0] POS_ID   = 2'd2;
    localparam logic [1:0] POS_LEN  = 2'd3;

    logic [7:0]       mem [STORE_DEPTH];
    logic [7:0]       rd_data_reg;

    logic [2:0]       state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    held_reg, held_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic             sv_reg, sv_next;

    logic             in_acc;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [OFF_W-1:0] total;
    logic [OFF_W-1:0] last_off;
    logic [OFF_W-1:0] drop_n;
    logic             hdr_ok;
    logic             issue;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        return (s >= DEPTH_EXT) ? AW'(s - DEPTH_EXT) : s[AW-1:0];
    endfunction

    assign full     = (held_reg == DEPTH_CNT);
    assign in_acc   = push & ~full;
    assign wr_addr  = wrap({1'b0, head_reg} + (AW + 1)'(held_reg));
    assign rd_addr  = wrap({1'b0, head_reg} + (AW + 1)'(off_reg));
    assign total    = OFF_W'(len_reg) + OFF_W'(HDR_TRL_LEN);
    assign last_off = OFF_W'(len_reg) + OFF_W'(HDR_LEN - 1);
    assign issue    = (off_reg < total);

    always_comb
    begin
        case (off_reg[1:0])
            POS_PRE:  hdr_ok = (rd_data_reg == cfg.preamble);
            POS_ADDR: hdr_ok = (rd_data_reg == cfg.address);
            POS_ID:   hdr_ok = (rd_data_reg == cfg.msg_id);
            default:  hdr_ok = (rd_data_reg != LEN_EXT_MARK);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        sv_next    = 1'b0;
        drop_n     = '0;
        tok_push   = 1'b0;
        tok        = '0;

        case (state_reg)
            ST_START:
            begin
                if (held_reg >= CW'(HDR_TRL_LEN))
                begin
                    off_next   = '0;
                    state_next = ST_HREQ;
                end
            end
            ST_HREQ:
            begin
                state_next = ST_HCHK;
            end
            ST_HCHK:
            begin
                if (!hdr_ok)
                begin
                    drop_n     = OFF_W'(1);
                    state_next = ST_START;
                end
                else if (off_reg[1:0] == POS_LEN)
                begin
                    len_next   = rd_data_reg;
                    state_next = ST_FWAIT;
                end
                else
                begin
                    off_next   = off_reg + OFF_W'(1);
                    state_next = ST_HREQ;
                end
            end
            ST_FWAIT:
            begin
                // a new byte means a fresh look at the header
                if (in_acc)
                begin
                    state_next = ST_START;
                end
                else if (held_reg >= CW'(total))
                begin
                    off_next   = OFF_W'(1);
                    sum_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (issue)
                begin
                    off_next = off_reg + OFF_W'(1);
                end
                sv_next = issue;
                if (sv_reg)
                begin
                    sum_next = sum_reg + rd_data_reg;
                end
                if (!issue && !sv_reg)
                begin
                    if (sum_reg == '0)
                    begin
                        off_next   = OFF_W'(HDR_LEN);
                        state_next = (len_reg == '0) ? ST_EEMPTY : ST_EREQ;
                    end
                    else
                    begin
                        drop_n     = OFF_W'(1);
                        state_next = ST_START;
                    end
                end
            end
            ST_EREQ:
            begin
                state_next = ST_EPUSH;
            end
            ST_EPUSH:
            begin
                if (!tok_full)
                begin
                    tok_push   = 1'b1;
                    tok.data   = rd_data_reg;
                    tok.len    = len_reg;
                    tok.last   = (off_reg == last_off);
                    tok.empty  = 1'b0;
                    if (off_reg == last_off)
                    begin
                        drop_n     = total;
                        state_next = ST_START;
                    end
                    else
                    begin
                        off_next   = off_reg + OFF_W'(1);
                        state_next = ST_EREQ;
                    end
                end
            end
            ST_EEMPTY:
            begin
                if (!tok_full)
                begin
                    tok_push   = 1'b1;
                    tok.data   = '0;
                    tok.len    = len_reg;
                    tok.last   = 1'b1;
                    tok.empty  = 1'b1;
                    drop_n     = total;
                    state_next = ST_START;
                end
            end
            default:
            begin
                state_next = ST_START;
            end
        endcase

        head_next = wrap({1'b0, head_reg} + (AW + 1)'(drop_n));
        held_next = held_reg + CW'(in_acc) - CW'(drop_n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            head_reg  <= '0;
            held_reg  <= '0;
            off_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            sv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            held_reg  <= held_next;
            off_reg   <= off_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            sv_reg    <= sv_next;
        end
    end

    // byte store: one write port at the tail, one registered read port
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mem[wr_addr] <= rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= DEPTH_CNT)
        else $error("store count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < DEPTH_EXT[AW-1:0] || DEPTH_EXT[AW])
        else $error("head pointer out of range");

    a_drop_held: assert property (@(posedge clk) disable iff (!rst_n)
        (drop_n != '0) |-> (CW'(drop_n) <= held_reg))
        else $error("discard beyond held bytes");

    a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
        tok_push |-> (state_reg == ST_EPUSH || state_reg == ST_EEMPTY))
        else $error("token pushed outside emit");

    a_wait_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FWAIT) |-> (len_reg != LEN_EXT_MARK))
        else $error("extended length passed the header check");

endmodule

// ===== rtl/sff_packer.sv =====
// ============================================================================
// sff_packer
// Packs data byte tokens into 64-bit result words.
// ============================================================================
module sff_packer (
    input  logic             clk,
    input  logic             rst_n,
    input  sff_pkg::token_t  tok,
    input  logic             tok_empty,
    output logic             tok_pop,
    input  logic             res_full,
    output logic             res_push,
    output sff_pkg::result_t res
);
    import sff_pkg::*;

    logic [63:0] word_reg, word_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] word_ins;

    assign tok_pop  = ~tok_empty & ~res_full;
    assign res_push = tok_pop & (tok.empty | tok.last | (cnt_reg == 3'd7));

    // earliest byte lands in the top lane
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            word_ins[8*(7-i) +: 8] = (cnt_reg == 3'(i)) ? tok.data : word_reg[8*(7-i) +: 8];
        end
    end

    always_comb
    begin
        res.word  = tok.empty ? '0 : word_ins;
        res.count = tok.empty ? '0 : ({1'b0, cnt_reg} + 4'd1);
        res.len   = tok.len;
        res.last  = tok.last;

        word_next = word_reg;
        cnt_next  = cnt_reg;
        if (tok_pop)
        begin
            if (res_push)
            begin
                word_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                word_next = word_ins;
                cnt_next  = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/sensor_frame_finder.sv =====
// Throughput: one byte taken per cycle while the store has room. The pace at which the
//   scanner drops a misaligned head byte and streams data bytes is set by the single
//   read port of the byte store.
// Reset (rst_n low, async): pointers, counters, queues cleared, registers to defaults.
// ============================================================================
// sensor_frame_finder
// Deframer for preamble / address / id / length / checksum frames, one result
// per 8-byte data word of every passing frame, and one zero word for an empty one.
// ============================================================================
module sensor_frame_finder #(
    parameter int STORE_DEPTH = sff_pkg::STORE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // byte requests in
    input  logic                         push,
    input  logic [7:0]                   rx_byte,
    output logic                         full,
    // result requests out
    output logic                         empty,
    input  logic                         pop,
    output logic [63:0]                  data_word,
    output logic [3:0]                   byte_count,
    output logic [7:0]                   payload_length,
    output logic                         last_of_frame,
    // register writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                   cfg_data
);
    import sff_pkg::*;

    // Front: sff_scanner holds received bytes in a circular store and walks
    // the head candidate through header check, checksum and data streaming.
    // A failed candidate drops only its head byte so the search slides by one.
    // Middle: a short token queue of data bytes lets the scanner run ahead.
    // Back: sff_packer builds 64-bit words, feeding the result queue.

    cfg_t    cfg_reg, cfg_next;
    token_t  tok_in, tok_out;
    logic    tok_push, tok_full, tok_pop, tok_empty;
    result_t res_in, res_out;
    logic    res_push, res_full;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PREAMBLE: cfg_next.preamble = cfg_data;
                REG_ADDRESS:  cfg_next.address  = cfg_data;
                REG_MSG_ID:   cfg_next.msg_id   = cfg_data;
                default:      cfg_next = cfg_reg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble <= PREAMBLE_RST;
            cfg_reg.address  <= ADDRESS_RST;
            cfg_reg.msg_id   <= MSG_ID_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sff_scanner #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_scanner (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .rx_byte  (rx_byte),
        .full     (full),
        .cfg      (cfg_reg),
        .tok_full (tok_full),
        .tok_push (tok_push),
        .tok      (tok_in)
    );

    sff_fifo #(
        .WIDTH ($bits(token_t)),
        .DEPTH (TOK_DEPTH)
    ) u_tok_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .din   (tok_in),
        .full  (tok_full),
        .pop   (tok_pop),
        .dout  (tok_out),
        .empty (tok_empty)
    );

    sff_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok_out),
        .tok_empty (tok_empty),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue: the oldest word sits on the ports while empty is low
    sff_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign data_word      = res_out.word;
    assign byte_count     = res_out.count;
    assign payload_length = res_out.len;
    assign last_of_frame  = res_out.last;

endmodule

// ===== sim/tb_sensor_frame_finder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_sensor_frame_finder
// Self-checking bench for the frame finder. A short table of hand-picked bytes
// runs first. Random frame traffic follows under four register settings. A
// bit-accurate predictor turns every accepted byte into the data words it
// should release, and each popped word is checked against the oldest one.
// ============================================================================
module tb_sensor_frame_finder;
    import sff_pkg::*;

    localparam int IDLE_PCT           = 23;      // chance of a bubble per cycle, each side
    localparam int PHASE_BYTES        = 20;      // random bytes per register setting, at least
    localparam int PHASE_WORDS        = 4;       // and at least this many words released
    localparam int MAX_WORDS_PER_BYTE = 52;      // release budget of one byte request
    localparam int HOLD_CYCLES        = 2000;    // receiver hold-off while the store floods
    localparam int FLOOD_BYTES        = 270;     // filler bytes sent during the hold-off
    localparam int QUIET_CYCLES       = 3000;    // drain time once nothing is pending
    localparam int LIMIT_CYCLES       = 400000;
    localparam int MAX_REPORTS        = 10;

    // ways a random frame can be spoiled on purpose
    typedef enum int { CLEAN, BAD_SUM, BAD_HEADER, CUT_SHORT, LEN_MARK } frame_flaw_e;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_WORD = '0;
    localparam int DIR_LEN = 22;

    // Directed walk at reset settings (preamble FA, address FF, id 32):
    // - rows 0..3 : fewer than five bytes held, nothing is judged; 00 and FF both seen
    // - row 4     : the leading 00 is not a preamble, so it slides out
    // - row 5     : checksum closes an empty frame -> one zero word, last set
    // - rows 6..10: a length of 255 is the extended mark, the candidate is refused
    // - rows 11..15: scan slides through the leftovers; the one-byte frame
    //               has a good header but is incomplete, so it just waits
    // - row 16    : checksum completes it -> D5 in the top byte
    // - rows 17..21: good header, wrong checksum -> head byte dropped, no word
    localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
        '{8'h00, 1'b0, NO_WORD},
        '{8'hFA, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h32, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'hCF, 1'b1, '{64'h0, 4'd0, 8'd0, 1'b1}},
        '{8'hFA, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h32, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'hFA, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h32, 1'b0, NO_WORD},
        '{8'h01, 1'b0, NO_WORD},
        '{8'hD5, 1'b0, NO_WORD},
        '{8'hF9, 1'b1, '{64'hD500_0000_0000_0000, 4'd1, 8'd1, 1'b1}},
        '{8'hFA, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'h32, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic [7:0]           rx_byte;
    logic                 full;
    logic                 empty;
    logic                 pop;
    logic [63:0]          data_word;
    logic [3:0]           byte_count;
    logic [7:0]           payload_length;
    logic                 last_of_frame;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // predictor state: its own copy of the registers and of the held bytes
    logic [7:0] want_preamble = PREAMBLE_RST;
    logic [7:0] want_address  = ADDRESS_RST;
    logic [7:0] want_msg_id   = MSG_ID_RST;
    logic [7:0] held_bytes [$];
    result_t    pending_words [$];   // words the block still owes, oldest first
    int         words_predicted = 0;
    int         bytes_fed = 0;
    int         mismatches = 0;
    int         cycles_run = 0;

    bit calm = 1'b0;            // both sides stop idling while set
    bit hold_off_req = 1'b0;    // asks the receiver for one long hold-off

    result_t seen;
    result_t due;

    sensor_frame_finder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .rx_byte        (rx_byte),
        .full           (full),
        .empty          (empty),
        .pop            (pop),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .payload_length (payload_length),
        .last_of_frame  (last_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic void log_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch, %s: want word=%h count=%0d len=%0d last=%0b %s%h %s%0d %s%0d %s%0b",
                     what, want.word, want.count, want.len, want.last,
                     "| got word=", got.word, "count=", got.count,
                     "len=", got.len, "last=", got.last);
    endfunction

    // Takes one received byte and queues every word it releases. The scan
    // restarts from the head each time, so a register change applies to
    // bytes already held as soon as the next byte comes in.
    function automatic void absorb_byte(logic [7:0] b);
        int         len;
        int         total;
        int         words;
        int         made;
        int         i;
        int         w;
        int         k;
        logic [7:0] sum;
        result_t    r;

        made = 0;
        if (held_bytes.size() >= STORE_DEPTH_DEF)
            void'(held_bytes.pop_front());
        held_bytes.push_back(b);

        while (held_bytes.size() >= HDR_TRL_LEN)
        begin
            if (held_bytes[0] != want_preamble || held_bytes[1] != want_address ||
                held_bytes[2] != want_msg_id || held_bytes[3] == LEN_EXT_MARK)
            begin
                void'(held_bytes.pop_front());
                continue;
            end
            len   = held_bytes[3];
            total = len + HDR_TRL_LEN;
            if (held_bytes.size() < total)
                break;                              // good header, rest still to come
            sum = '0;
            for (i = 1; i < total; i++)
                sum = sum + held_bytes[i];
            if (sum != 8'd0)
            begin
                void'(held_bytes.pop_front());
                continue;
            end
            words = (len == 0) ? 1 : (len + 7) / 8;
            if (made + words > MAX_WORDS_PER_BYTE)
                break;                              // judged again on the next byte
            for (w = 0; w < words; w++)
            begin
                r = '0;
                for (k = 0; k < 8; k++)
                begin
                    if (w * 8 + k < len)
                    begin
                        r.word[63 - 8 * k -: 8] = held_bytes[HDR_LEN + w * 8 + k];
                        r.count = r.count + 4'd1;
                    end
                end
                r.len  = len[7:0];
                r.last = (w == words - 1);
                pending_words.push_back(r);
                made++;
            end
            held_bytes = held_bytes[total:$];
        end
        words_predicted += made;
    endfunction

    // Offers one byte request and waits for the block to take it.
    task automatic offer_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
        bytes_fed++;
        absorb_byte(b);
    endtask

    // Writes all three registers back to back, then drops valid.
    task automatic write_settings(input logic [7:0] pre, input logic [7:0] adr,
                                  input logic [7:0] mid);
        logic [7:0]           vals [3];
        logic [CFG_IDX_W-1:0] regs [3];
        int                   i;

        vals = '{pre, adr, mid};
        regs = '{REG_PREAMBLE, REG_ADDRESS, REG_MSG_ID};
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (regs[i])
                REG_PREAMBLE: want_preamble = vals[i];
                REG_ADDRESS:  want_address  = vals[i];
                REG_MSG_ID:   want_msg_id   = vals[i];
                default:      ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Waits for every owed word, then gives the scanner time to chew through
    // whatever it still holds; frames that fail release nothing to wait on.
    task automatic wait_quiet();
        push <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Builds one frame for the current settings, spoils it as asked, sends it.
    task automatic send_frame(input int len, input frame_flaw_e flaw);
        logic [7:0] fb [$];
        logic [7:0] ck;
        int         i;
        int         pos;

        fb = {want_preamble, want_address, want_msg_id, 8'(len)};
        for (i = 0; i < len; i++)
            fb.push_back(rand_byte());
        ck = '0;
        for (i = 1; i < fb.size(); i++)
            ck = ck - fb[i];
        fb.push_back(ck);
        case (flaw)
            BAD_SUM:
                fb[fb.size() - 1] = ck ^ 8'($urandom_range(255, 1));
            BAD_HEADER:
            begin
                pos = $urandom_range(2);
                fb[pos] = fb[pos] ^ 8'($urandom_range(255, 1));
            end
            CUT_SHORT:
                fb = fb[0:$urandom_range(fb.size() - 2, 0)];
            LEN_MARK:
                fb[3] = LEN_EXT_MARK;
            default: ;
        endcase
        foreach (fb[i])
            offer_byte(fb[i]);
    endtask

    // Mostly clean frames with random content; the rest are spoiled frames
    // and loose noise. Lengths stay short except now and then.
    task automatic run_traffic();
        int start_bytes;
        int start_words;
        int pick;
        int len;

        start_bytes = bytes_fed;
        start_words = words_predicted;
        while (bytes_fed - start_bytes < PHASE_BYTES ||
               words_predicted - start_words < PHASE_WORDS)
        begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24);
            if (pick < 60)
                send_frame(len, CLEAN);
            else if (pick < 70)
                send_frame(len, BAD_SUM);
            else if (pick < 78)
                send_frame(len, BAD_HEADER);
            else if (pick < 85)
                send_frame(len, CUT_SHORT);
            else if (pick < 90)
                send_frame(len, LEN_MARK);
            else
                repeat ($urandom_range(6, 1)) offer_byte(rand_byte());
        end
        // park a half-received frame so the next register write meets held bytes
        offer_byte(want_preamble);
        offer_byte(want_address);
        offer_byte(want_msg_id);
        offer_byte(8'($urandom_range(20, 2)));
        offer_byte(rand_byte());
    endtask

    // Receiver: random pops, one long hold-off on request.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                pop <= 1'b1;
            end
            else
                pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every popped word against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            seen = '{data_word, byte_count, payload_length, last_of_frame};
            if (pending_words.size() == 0)
                log_mismatch("word with none owed", NO_WORD, seen);
            else
            begin
                due = pending_words.pop_front();
                if (seen.word !== due.word || seen.count !== due.count ||
                    seen.len !== due.len || seen.last !== due.last)
                    log_mismatch("data word", due, seen);
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycles_run < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int         r;
        int         due_before;
        int         n;
        logic [7:0] junk;

        rst_n     <= 1'b0;
        push      <= 1'b0;
        rx_byte   <= '0;
        pop       <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_PREAMBLE;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings. Typed rows stand in for the
        // predictor's word, and any disagreement between the two is flagged.
        for (r = 0; r < DIR_LEN; r++)
        begin
            due_before = words_predicted;
            offer_byte(DIR_ROWS[r].rx);
            if (DIR_ROWS[r].typed)
            begin
                if (words_predicted != due_before + 1 ||
                    pending_words[pending_words.size() - 1] != DIR_ROWS[r].want)
                    log_mismatch("directed row", DIR_ROWS[r].want, NO_WORD);
                if (words_predicted == due_before + 1)
                    pending_words[pending_words.size() - 1] = DIR_ROWS[r].want;
            end
        end

        // Reset settings, random traffic.
        run_traffic();

        // All registers at zero; neither side idles for the whole stretch.
        wait_quiet();
        write_settings(8'h00, 8'h00, 8'h00);
        calm = 1'b1;
        run_traffic();
        calm = 1'b0;

        // All registers at FF. A maximum-length frame backs up its 32 words
        // while the receiver holds off; the filler behind it can never match,
        // so the store fills and push gets stalled.
        wait_quiet();
        write_settings(8'hFF, 8'hFF, 8'hFF);
        hold_off_req = 1'b1;
        calm = 1'b1;
        send_frame(254, CLEAN);
        for (n = 0; n < FLOOD_BYTES; n++)
        begin
            do
                junk = rand_byte();
            while (junk == want_preamble);
            offer_byte(junk);
        end
        calm = 1'b0;
        run_traffic();

        // Random settings.
        wait_quiet();
        write_settings(rand_byte(), rand_byte(), rand_byte());
        run_traffic();

        wait_quiet();
        if (mismatches == 0 && pending_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sff_pkg.sv
rtl/sff_fifo.sv
rtl/sff_scanner.sv
rtl/sff_packer.sv
rtl/sensor_frame_finder.sv
sim/tb_sensor_frame_finder.sv
